// ----- sv/cls_pkg.sv -----
// Shared types, constants and permutation table for the Cramer solver.
package cls_pkg;

  localparam int MAX_UNKNOWNS   = 4;
  localparam int EL_BITS_DEF    = 16;
  localparam int PERM_COUNT     = 24;
  localparam int FRAC_BITS      = 16;
  localparam int VAR_RESET      = 2;

  typedef enum logic [2:0] {
    T_LOAD, T_MAIN_GO, T_MAIN_WAIT, T_COL_GO, T_COL_WAIT, T_DIV_GO, T_DIV_WAIT, T_EMIT
  } top_state_t;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_ACC} det_state_t;

  typedef enum logic [1:0] {V_IDLE, V_RUN, V_DONE} div_state_t;

  typedef struct packed {
    logic       start;
    logic       col_en;
    logic [1:0] col;
    logic [2:0] n;
  } det_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } det_sts_t;

  // Column chosen for each row, {row3, row2, row1, row0}, lexicographic order.
  function automatic logic [7:0] perm_cols(input logic [4:0] p);
    logic [7:0] c;
    case (p)
      5'd0:    c = {2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:    c = {2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:    c = {2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:    c = {2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:    c = {2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:    c = {2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:    c = {2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:    c = {2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:    c = {2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:    c = {2'd0, 2'd3, 2'd2, 2'd1};
      5'd10:   c = {2'd2, 2'd0, 2'd3, 2'd1};
      5'd11:   c = {2'd0, 2'd2, 2'd3, 2'd1};
      5'd12:   c = {2'd3, 2'd1, 2'd0, 2'd2};
      5'd13:   c = {2'd1, 2'd3, 2'd0, 2'd2};
      5'd14:   c = {2'd3, 2'd0, 2'd1, 2'd2};
      5'd15:   c = {2'd0, 2'd3, 2'd1, 2'd2};
      5'd16:   c = {2'd1, 2'd0, 2'd3, 2'd2};
      5'd17:   c = {2'd0, 2'd1, 2'd3, 2'd2};
      5'd18:   c = {2'd2, 2'd1, 2'd0, 2'd3};
      5'd19:   c = {2'd1, 2'd2, 2'd0, 2'd3};
      5'd20:   c = {2'd2, 2'd0, 2'd1, 2'd3};
      5'd21:   c = {2'd0, 2'd2, 2'd1, 2'd3};
      5'd22:   c = {2'd1, 2'd0, 2'd2, 2'd3};
      5'd23:   c = {2'd0, 2'd1, 2'd2, 2'd3};
      default: c = {2'd3, 2'd2, 2'd1, 2'd0};
    endcase
    return c;
  endfunction

  localparam logic [PERM_COUNT-1:0] PERM_ODD = 24'b0110_0110_0110_0110_0110_0110;

  // A permutation belongs to the n x n expansion when it fixes rows n and up.
  function automatic logic perm_fits(input logic [7:0] c, input logic [2:0] n);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < MAX_UNKNOWNS; k++) begin
      if (k >= int'(n) && c[2*k +: 2] != 2'(k)) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ----- sv/cls_div.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module cls_div import cls_pkg::*; #(
  parameter int NW = 88,
  parameter int DW = 72
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  div_state_t    state_r, state_nxt;
  logic [DW-1:0] rem_r, den_r;
  logic [NW-1:0] num_r, q_r;
  logic [CW-1:0] cnt_r;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = q_r;
  assign done  = state_r == V_DONE;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= V_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      V_IDLE: if (start) state_nxt = V_RUN;
      V_RUN:  if (cnt_r == CW'(NW - 1)) state_nxt = V_DONE;
      V_DONE: state_nxt = V_IDLE;
      default: state_nxt = V_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == V_IDLE && start) begin
      rem_r <= '0;
      num_r <= num;
      den_r <= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (state_r == V_RUN) begin
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      num_r <= {num_r[NW-2:0], 1'b0};
      q_r   <= {q_r[NW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ----- sv/cls_det.sv -----
// Determinant engine: signed permutation sum through one shared multiplier.
module cls_det import cls_pkg::*; #(
  parameter int ELEMENT_BITS = EL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  det_req_t                       req,
  input  logic signed [ELEMENT_BITS-1:0] elem,
  output logic [1:0]                     rd_row,
  output logic [1:0]                     rd_col,
  output logic                           rd_const,
  output det_sts_t                       sts,
  output logic signed [4*ELEMENT_BITS+7:0] det_value
);

  localparam int PW = 4 * ELEMENT_BITS;
  localparam int AW = 4 * ELEMENT_BITS + 8;

  det_state_t            state_r, state_nxt;
  logic [4:0]            p_r;
  logic [1:0]            r_r, col_r;
  logic [2:0]            n_r;
  logic                  col_en_r, done_r;
  logic signed [PW-1:0]  prod_r, mul;
  logic signed [AW-1:0]  acc_r, term;
  logic [7:0]            pm;
  logic                  fits, last_p, last_r;

  assign pm       = perm_cols(p_r);
  assign fits     = perm_fits(pm, n_r);
  assign last_p   = p_r == 5'(PERM_COUNT - 1);
  assign last_r   = {1'b0, r_r} == n_r - 3'd1;
  assign rd_row   = r_r;
  assign rd_col   = pm[2*r_r +: 2];
  assign rd_const = col_en_r && rd_col == col_r;
  assign mul      = PW'($signed(prod_r[3*ELEMENT_BITS-1:0])) * PW'(elem);
  assign term     = PERM_ODD[p_r] ? -AW'(prod_r) : AW'(prod_r);
  assign det_value = acc_r;
  assign sts.busy = state_r != D_IDLE;
  assign sts.done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= D_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE: if (req.start) state_nxt = D_MUL;
      D_MUL: begin
        if (!fits) begin
          if (last_p) state_nxt = D_IDLE;
        end else if (last_r) state_nxt = D_ACC;
      end
      D_ACC: state_nxt = last_p ? D_IDLE : D_MUL;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == D_MUL && !fits && last_p) || (state_r == D_ACC && last_p);
    end
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          p_r      <= '0;
          r_r      <= '0;
          prod_r   <= PW'(1);
          acc_r    <= '0;
          n_r      <= req.n;
          col_en_r <= req.col_en;
          col_r    <= req.col;
        end
      end
      D_MUL: begin
        if (!fits) begin
          p_r <= p_r + 5'd1;
        end else begin
          prod_r <= mul;
          r_r    <= r_r + 2'd1;
        end
      end
      D_ACC: begin
        acc_r  <= acc_r + term;
        prod_r <= PW'(1);
        r_r    <= '0;
        p_r    <= p_r + 5'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cramer_linear_solver_core.sv -----
// Top level of the Cramer's rule solver for 2 to 4 unknowns.
//
// Usage: write var_count (n) on the cfg_ channel; a write also drops any
// partly loaded system. Then send n*n coefficients row by row followed by
// n constants as items on the in_ channel, each a signed Q8.8 value.
// Load items are taken whenever in_valid is high and in_stall low. After the
// last constant the block stalls its input while it solves: one determinant
// steps the permutation sequencer through all 24 permutations, multiplying
// in one element per row for each of the n! terms that fit n and skipping
// the rest, and n+1 determinants are formed (only the first if it is zero).
// Each quotient then goes through a bit-serial divider. The shared
// multiplier and the divider set the solve time.
// Results leave on the out_ channel, one Q16.16 item per unknown with
// last_result on the final one, or a single no_solution item if the
// coefficient determinant is zero. A stalled result is held in the output
// register; the solver waits for it before presenting the next one.
// Reset (synchronous, rst_n low) clears the load counter, sets var_count to
// 2 and empties the output register; stored elements are not cleared.
module cramer_linear_solver_core import cls_pkg::*; #(
  parameter int ELEMENT_BITS = EL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_element_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_var_index,
  output logic [31:0] out_solution_value,
  output logic        out_no_solution,
  output logic        out_saturated,
  output logic        out_last_result
);

  localparam int EB = ELEMENT_BITS;
  localparam int AW = 4 * EB + 8;          // exact determinant width
  localparam int NW = AW + FRAC_BITS;      // shifted numerator width

  top_state_t state_r, state_nxt;

  // configuration and load bookkeeping
  logic [2:0] var_count_r, n_eff;
  logic [4:0] lc_r, nn, total;
  logic       in_acc, cfg_acc, last_in;

  // element stores, written in load order, read by the determinant engine
  logic signed [EB-1:0] coef_r [16];
  logic signed [EB-1:0] const_r [MAX_UNKNOWNS];

  // solve datapath
  det_req_t             det_req;
  det_sts_t             det_sts;
  logic [1:0]           rd_row, rd_col;
  logic                 rd_const;
  logic signed [EB-1:0] elem;
  logic [3:0]           coef_idx;
  logic signed [AW-1:0] det_value;
  logic [AW-1:0]        dmag_r, di_mag;
  logic                 dneg_r, qneg_r;
  logic [1:0]           var_r;
  logic                 div_start, div_done;
  logic [NW-1:0]        quo;

  // result formatting
  logic        sat_pos, sat_neg, sat;
  logic [31:0] sol;
  logic        out_free, emit;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_idx_r;
  logic [31:0] out_sol_r;
  logic        out_ns_r, out_sat_r, out_last_r;

  // var_count below 2 behaves as 2, above the maximum as the maximum
  always_comb begin
    if (var_count_r < 3'd2) n_eff = 3'd2;
    else if (var_count_r > 3'(MAX_UNKNOWNS)) n_eff = 3'(MAX_UNKNOWNS);
    else n_eff = var_count_r;
  end

  assign nn      = {2'b00, n_eff} * {2'b00, n_eff};
  assign total   = nn + 5'(n_eff);
  assign in_stall  = state_r != T_LOAD;
  assign cfg_ready = state_r == T_LOAD;
  assign in_acc  = in_valid && !in_stall;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign last_in = lc_r + 5'd1 == total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= 3'(VAR_RESET);
      lc_r        <= '0;
    end else if (cfg_acc) begin
      var_count_r <= cfg_data;
      lc_r        <= '0;
    end else if (in_acc) begin
      lc_r <= last_in ? 5'd0 : lc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (lc_r < nn) coef_r[lc_r[3:0]] <= $signed(in_element_value[EB-1:0]);
      else           const_r[2'(lc_r - nn)] <= $signed(in_element_value[EB-1:0]);
    end
  end

  // element feed for the determinant engine; stride n, row major
  assign coef_idx = {2'b00, rd_row} * {1'b0, n_eff} + {2'b00, rd_col};
  assign elem     = rd_const ? const_r[rd_row] : coef_r[coef_idx];

  assign det_req.start  = state_r == T_MAIN_GO || state_r == T_COL_GO;
  assign det_req.col_en = state_r == T_COL_GO;
  assign det_req.col    = var_r;
  assign det_req.n      = n_eff;

  cls_det #(.ELEMENT_BITS(EB)) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (det_req),
    .elem      (elem),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .rd_const  (rd_const),
    .sts       (det_sts),
    .det_value (det_value)
  );

  assign di_mag    = det_value[AW-1] ? AW'(-det_value) : AW'(det_value);
  assign div_start = state_r == T_DIV_GO;

  cls_div #(.NW(NW), .DW(AW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({di_mag, FRAC_BITS'(0)}),
    .den   (dmag_r),
    .quo   (quo),
    .done  (div_done)
  );

  // clip to Q16.16: the negative side reaches one step further
  assign sat_pos = |quo[NW-1:31];
  assign sat_neg = (|quo[NW-1:32]) || (quo[31] && |quo[30:0]);
  assign sat     = qneg_r ? sat_neg : sat_pos;
  always_comb begin
    if (qneg_r) sol = sat ? 32'h8000_0000 : 32'(-quo[31:0]);
    else        sol = sat ? 32'h7FFF_FFFF : quo[31:0];
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = state_r == T_EMIT && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= T_LOAD;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_LOAD:      if (in_acc && last_in) state_nxt = T_MAIN_GO;
      T_MAIN_GO:   state_nxt = T_MAIN_WAIT;
      T_MAIN_WAIT: if (det_sts.done) state_nxt = (det_value == '0) ? T_EMIT : T_COL_GO;
      T_COL_GO:    state_nxt = T_COL_WAIT;
      T_COL_WAIT:  if (det_sts.done) state_nxt = T_DIV_GO;
      T_DIV_GO:    state_nxt = T_DIV_WAIT;
      T_DIV_WAIT:  if (div_done) state_nxt = T_EMIT;
      T_EMIT: begin
        if (out_free) begin
          if (dmag_r == '0 || {1'b0, var_r} == n_eff - 3'd1) state_nxt = T_LOAD;
          else state_nxt = T_COL_GO;
        end
      end
      default: state_nxt = T_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == T_MAIN_WAIT && det_sts.done) begin
      dmag_r <= di_mag;
      dneg_r <= det_value[AW-1];
      var_r  <= '0;
    end
    if (state_r == T_COL_WAIT && det_sts.done) qneg_r <= det_value[AW-1] != dneg_r;
    if (emit) var_r <= var_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      if (dmag_r == '0) begin
        out_idx_r  <= '0;
        out_sol_r  <= '0;
        out_ns_r   <= 1'b1;
        out_sat_r  <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_idx_r  <= var_r;
        out_sol_r  <= sol;
        out_ns_r   <= 1'b0;
        out_sat_r  <= sat;
        out_last_r <= {1'b0, var_r} == n_eff - 3'd1;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_var_index      = out_idx_r;
  assign out_solution_value = out_sol_r;
  assign out_no_solution    = out_ns_r;
  assign out_saturated      = out_sat_r;
  assign out_last_result    = out_last_r;

  a_load_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    lc_r < total) else $error("load count past end of system");

  a_det_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    det_req.start |-> !det_sts.busy) else $error("determinant started while busy");

  a_nosol_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_solution) |-> out_last_result && !out_saturated)
    else $error("no-solution item not final");

endmodule

// ----- test/cramer_linear_solver_core_tb.sv -----
// Self-checking testbench for the Cramer's rule solver: directed systems, then random ones.
module cramer_linear_solver_core_tb import cls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // One solution item as it leaves the out_ channel
  typedef struct {
    logic [1:0]  var_index;
    logic [31:0] solution_value;
    logic        no_solution;
    logic        saturated;
    logic        last_result;
  } solution_t;

  typedef logic signed [127:0] wide_t;
  typedef wide_t mat_t [4][4];

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 1200;
  localparam int CFG_SETTLE  = 30;
  localparam int DIR_ITEMS   = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_element_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_var_index;
  logic [31:0] out_solution_value;
  logic        out_no_solution;
  logic        out_saturated;
  logic        out_last_result;

  cramer_linear_solver_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: own copy of the stores, load counter and unknown count
  logic signed [15:0] coef_mem [16];
  logic signed [15:0] const_mem [4];
  int unsigned        elems_loaded;
  logic [2:0]         unknowns_reg;

  solution_t pending_solutions[$];
  int        mismatches;
  int        cycles;
  bit        in_burst, out_burst;

  // 3x3 minor on chosen rows and columns, exact at 128 bits
  function automatic wide_t minor3(mat_t m, int r0, int r1, int r2, int c0, int c1, int c2);
    return m[r0][c0] * (m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1])
         - m[r0][c1] * (m[r1][c0] * m[r2][c2] - m[r1][c2] * m[r2][c0])
         + m[r0][c2] * (m[r1][c0] * m[r2][c1] - m[r1][c1] * m[r2][c0]);
  endfunction

  function automatic wide_t determinant(mat_t m, int n);
    wide_t acc;
    acc = '0;
    case (n)
      2: acc = m[0][0] * m[1][1] - m[0][1] * m[1][0];
      3: acc = minor3(m, 0, 1, 2, 0, 1, 2);
      default: begin
        // expand along row 0
        acc = m[0][0] * minor3(m, 1, 2, 3, 1, 2, 3)
            - m[0][1] * minor3(m, 1, 2, 3, 0, 2, 3)
            + m[0][2] * minor3(m, 1, 2, 3, 0, 1, 3)
            - m[0][3] * minor3(m, 1, 2, 3, 0, 1, 2);
      end
    endcase
    return acc;
  endfunction

  function automatic int active_unknowns();
    if (unknowns_reg < 3'd2) return 2;
    if (unknowns_reg > 3'(MAX_UNKNOWNS)) return MAX_UNKNOWNS;
    return int'(unknowns_reg);
  endfunction

  // Loads one element; on the last constant, works out the solution items.
  // Returns them in sols (empty while loading).
  task automatic solve_system(input logic signed [15:0] v, output solution_t sols[$]);
    int n, nn;
    mat_t base, m;
    wide_t d, di;
    logic [127:0] dmag, num, q;
    bit neg;
    solution_t s;
    sols = {};
    n = active_unknowns();
    nn = n * n;
    if (elems_loaded < nn) coef_mem[elems_loaded] = v;
    else const_mem[elems_loaded - nn] = v;
    elems_loaded++;
    if (elems_loaded < nn + n) return;
    elems_loaded = 0;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        base[r][c] = (r < n && c < n) ? wide_t'(coef_mem[r * n + c]) : '0;
    d = determinant(base, n);
    if (d == 0) begin
      s = '{2'd0, 32'd0, 1'b1, 1'b0, 1'b1};
      sols.push_back(s);
      return;
    end
    dmag = d < 0 ? -d : d;
    for (int i = 0; i < n; i++) begin
      m = base;
      for (int r = 0; r < n; r++) m[r][i] = wide_t'(const_mem[r]);
      di = determinant(m, n);
      neg = (di < 0) != (d < 0);
      num = (di < 0 ? -di : di) << FRAC_BITS;
      q = num / dmag;
      s.var_index = 2'(i);
      s.no_solution = 1'b0;
      s.saturated = 1'b0;
      s.last_result = (i == n - 1);
      if (neg) begin
        if (q > 128'h8000_0000) begin
          s.saturated = 1'b1;
          s.solution_value = 32'h8000_0000;
        end else begin
          s.solution_value = 32'(-q);
        end
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          s.saturated = 1'b1;
          s.solution_value = 32'h7FFF_FFFF;
        end else begin
          s.solution_value = 32'(q);
        end
      end
      sols.push_back(s);
    end
  endtask

  // Drive one element; returns once the block has taken it
  task automatic send_element(input logic [15:0] v, output solution_t sols[$]);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= v;
    do @(posedge clk); while (in_stall);
    solve_system(v, sols);
  endtask

  task automatic send_and_predict(input logic [15:0] v);
    solution_t sols[$];
    send_element(v, sols);
    foreach (sols[k]) pending_solutions.push_back(sols[k]);
  endtask

  // Register writes only when nothing is in flight
  task automatic write_unknowns(input logic [2:0] v);
    in_valid <= 1'b0;
    wait (pending_solutions.size() == 0);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unknowns_reg = v;
    elems_loaded = 0;
  endtask

  function automatic logic [15:0] draw_element();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  // Well-formed system with random content; sometimes forced singular
  task automatic send_random_system(ref int sent);
    int n;
    logic [15:0] vals[$];
    n = active_unknowns();
    for (int k = 0; k < n * n + n; k++) vals.push_back(draw_element());
    if ($urandom_range(0, 4) == 0)
      for (int c = 0; c < n; c++) vals[n + c] = vals[c];   // row 1 copies row 0
    foreach (vals[k]) send_and_predict(vals[k]);
    sent += vals.size();
  endtask

  // Result side: draws a stall length per item, sometimes runs flat out
  initial begin : result_stall
    int hold;
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Checker: compares every accepted result with the oldest expectation
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_solutions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d val %h nosol %b sat %b last %b",
                   out_var_index, out_solution_value, out_no_solution,
                   out_saturated, out_last_result);
      end else begin
        want = pending_solutions.pop_front();
        if (want.var_index !== out_var_index || want.solution_value !== out_solution_value
            || want.no_solution !== out_no_solution || want.saturated !== out_saturated
            || want.last_result !== out_last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d val %h nosol %b sat %b last %b | got idx %0d val %h nosol %b sat %b last %b",
                     want.var_index, want.solution_value, want.no_solution,
                     want.saturated, want.last_result, out_var_index,
                     out_solution_value, out_no_solution, out_saturated,
                     out_last_result);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Directed systems at the reset value of two unknowns: identity, all zero
  // (singular), a clipped pair and the element extremes.
  logic [15:0] dir_elems [DIR_ITEMS] = '{
    16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'hFF00,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h7FFF, 16'h8000,
    16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF
  };
  // number of hand-written results attached to each element
  int dir_nexp [DIR_ITEMS] = '{
    0, 0, 0, 0, 0, 2,
    0, 0, 0, 0, 0, 1,
    0, 0, 0, 0, 0, 2,
    0, 0, 0, 0, 0, 0
  };
  solution_t dir_results[$];

  initial begin : stimulus
    solution_t sols[$];
    logic [2:0] phase_cfg [10] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6, 3'd3};
    int sent, budget, junk;
    mismatches = 0;
    cycles = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    elems_loaded = 0;
    unknowns_reg = 3'(VAR_RESET);
    dir_results = '{
      '{2'd0, 32'h0001_0000, 1'b0, 1'b0, 1'b0},
      '{2'd1, 32'hFFFF_0000, 1'b0, 1'b0, 1'b1},
      '{2'd0, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
      '{2'd0, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0},
      '{2'd1, 32'h8000_0000, 1'b0, 1'b1, 1'b1}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: typed results where given, predictor otherwise
    for (int k = 0; k < DIR_ITEMS; k++) begin
      send_element(dir_elems[k], sols);
      if (dir_nexp[k] > 0) begin
        repeat (dir_nexp[k]) pending_solutions.push_back(dir_results.pop_front());
      end else begin
        foreach (sols[j]) pending_solutions.push_back(sols[j]);
      end
    end

    // Random phases, one register setting each
    sent = 0;
    foreach (phase_cfg[p]) begin
      // now and then leave a half-loaded system for the write to drop
      if ($urandom_range(0, 2) == 0) begin
        junk = $urandom_range(1, 5);
        repeat (junk) send_and_predict(draw_element());
        sent += junk;
      end
      write_unknowns(phase_cfg[p]);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      budget = sent + 35;
      while (sent < budget) send_random_system(sent);
    end
    in_valid <= 1'b0;

    wait (pending_solutions.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- cramer_linear_solver_core.f -----
sv/cls_pkg.sv
sv/cls_div.sv
sv/cls_det.sv
sv/cramer_linear_solver_core.sv
test/cramer_linear_solver_core_tb.sv
